// File: rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_ON(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/dqs_pkg.sv
package dqs_pkg;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_REM  = 2'd2,
    KIND_SORT = 2'd3
  } kind_t;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned ENTRIES_W = 5;
  localparam int unsigned NUM_VALUES = 16;

  typedef struct packed {
    kind_t              kind;
    logic [DIGIT_W-1:0] digit_in;
  } in_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0]   digit_out;
    logic                 ok;
    logic [ENTRIES_W-1:0] entries_now;
  } out_item_t;

endpackage

// File: rtl/dqs_ram.sv
module dqs_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [dqs_pkg::DIGIT_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [dqs_pkg::DIGIT_W-1:0] rdata
);
  import dqs_pkg::*;

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/digit_queue_with_sort.sv
// Bounded FIFO of 4-bit digits with enqueue, dequeue, remove-first-match and
// ascending sort; every item yields one result (digit, ok flag, new count).
// All work runs through a digit RAM with one write port and one registered
// read port, so the RAM ports set the rate. Removal scans up to the match,
// then closes the gap over the rest; sort makes a tally pass, then a
// write-back walk over the 16 digit values. Input is stalled while an item
// is in work or its result has not been taken. No clearing pass is needed
// after reset; only held entries are ever read.
module digit_queue_with_sort #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dqs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dqs_pkg::out_item_t out_data
);
  import dqs_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENQ,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_TALLY_RD,
    ST_TALLY_ACC,
    ST_FILL,
    ST_DONE
  } state_t;

  state_t             state_r;
  kind_t              kind_r;
  logic [DIGIT_W-1:0] digit_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;
  logic [DIGIT_W-1:0] val_r;
  logic [CW-1:0]      tally_r [NUM_VALUES];
  logic [DIGIT_W-1:0] res_digit_r;
  logic               res_ok_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [DIGIT_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  logic [CW-1:0]      idx_inc;
  logic [CW+ENTRIES_W-1:0] count_ext;
  logic               accept;

  assign idx_inc   = idx_r + 1'b1;
  assign count_ext = {{ENTRIES_W{1'b0}}, count_r};
  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[AW-1:0];
    unique case (state_r)
      ST_ENQ: begin
        ram_we    = (count_r != FULL);
        ram_waddr = count_r[AW-1:0];
        ram_wdata = digit_r;
      end
      ST_SHIFT_RD: ram_raddr = idx_inc[AW-1:0];
      ST_SHIFT_WR: ram_we = 1'b1;
      ST_FILL: begin
        ram_we    = (tally_r[val_r] != '0);
        ram_wdata = val_r;
      end
      default: ;
    endcase
  end

  dqs_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            kind_r  <= in_data.kind;
            digit_r <= in_data.digit_in;
            idx_r   <= '0;
            unique case (in_data.kind)
              KIND_ENQ: state_r <= ST_ENQ;
              KIND_DEQ, KIND_REM: state_r <= ST_SCAN_RD;
              KIND_SORT: begin
                for (int v = 0; v < NUM_VALUES; v++) begin
                  tally_r[v] <= '0;
                end
                state_r <= ST_TALLY_RD;
              end
            endcase
          end
        end
        ST_ENQ: begin
          res_digit_r <= '0;
          res_ok_r    <= (count_r != FULL);
          if (count_r != FULL) begin
            count_r <= count_r + 1'b1;
          end
          state_r <= ST_DONE;
        end
        ST_SCAN_RD: begin
          if (idx_r == count_r) begin
            res_digit_r <= '0;
            res_ok_r    <= 1'b0;
            state_r     <= ST_DONE;
          end else begin
            state_r <= ST_SCAN_CMP;
          end
        end
        ST_SCAN_CMP: begin
          // dequeue matches the head unconditionally
          if (kind_r == KIND_DEQ || ram_rdata == digit_r) begin
            res_digit_r <= ram_rdata;
            res_ok_r    <= 1'b1;
            state_r     <= ST_SHIFT_RD;
          end else begin
            idx_r   <= idx_inc;
            state_r <= ST_SCAN_RD;
          end
        end
        ST_SHIFT_RD: begin
          if (idx_inc == count_r) begin
            count_r <= count_r - 1'b1;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_SHIFT_WR;
          end
        end
        ST_SHIFT_WR: begin
          idx_r   <= idx_inc;
          state_r <= ST_SHIFT_RD;
        end
        ST_TALLY_RD: begin
          if (idx_r == count_r) begin
            idx_r   <= '0;
            val_r   <= '0;
            state_r <= ST_FILL;
          end else begin
            state_r <= ST_TALLY_ACC;
          end
        end
        ST_TALLY_ACC: begin
          tally_r[ram_rdata] <= tally_r[ram_rdata] + 1'b1;
          idx_r   <= idx_inc;
          state_r <= ST_TALLY_RD;
        end
        ST_FILL: begin
          if (tally_r[val_r] != '0) begin
            tally_r[val_r] <= tally_r[val_r] - 1'b1;
            idx_r          <= idx_inc;
          end else if (val_r == DIGIT_W'(NUM_VALUES - 1)) begin
            res_digit_r <= '0;
            res_ok_r    <= 1'b1;
            state_r     <= ST_DONE;
          end else begin
            val_r <= val_r + 1'b1;
          end
        end
        ST_DONE: begin
          out_valid_r            <= 1'b1;
          out_data_r.digit_out   <= res_digit_r;
          out_data_r.ok          <= res_ok_r;
          out_data_r.entries_now <= count_ext[ENTRIES_W-1:0];
          state_r                <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/dqs_checker.sv
`include "assert_macros.svh"

module dqs_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dqs_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dqs_pkg::out_item_t out_data
);
  import dqs_pkg::*;

  localparam int unsigned CAP = (QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH;

  `ASSERT_ON(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "result dropped or changed while stalled")

  // one item at a time: an accepted item blocks the input on the next edge
  `ASSERT_ON(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "input not stalled after accept")

  `ASSERT_ON(a_fail_zero_digit, clk, rst_n, out_valid && !out_data.ok |-> out_data.digit_out == '0, "failed result carries a digit")

  `ASSERT_ON(a_count_bound, clk, rst_n, out_valid && (CAP < 31) |-> out_data.entries_now <= CAP, "count beyond queue depth")

endmodule

bind digit_queue_with_sort dqs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dqs_checker (.*);
